### rtl/gcl_pkg.sv
// ----------------------------------------------------------------------------
// gcl_pkg
// Shared types and constants for the graph district / path engine.
// ----------------------------------------------------------------------------
package gcl_pkg;

  localparam int KEY_W    = 16;
  localparam int OPC_W    = 3;
  localparam int STATUS_W = 4;
  localparam int DIST_W   = 7;
  localparam int COUNT_W  = 7;

  typedef enum logic [OPC_W-1:0] {
    OPC_ADD_VERTEX = 3'd0,
    OPC_ADD_EDGE   = 3'd1,
    OPC_ASSIGN     = 3'd2,
    OPC_QUERY      = 3'd3,
    OPC_PATH       = 3'd4
  } opc_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 4'd0,
    ST_DUP         = 4'd1,
    ST_FULL        = 4'd2,
    ST_UNKNOWN     = 4'd3,
    ST_ADJ_FULL    = 4'd4,
    ST_SELF_LOOP   = 4'd5,
    ST_UNASSIGNED  = 4'd6,
    ST_OTHER_DIST  = 4'd7,
    ST_UNREACHABLE = 4'd8
  } status_t;

  // datapath micro-operations
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LATCH,
    DP_FIND_RD,
    DP_FIND_CMP,
    DP_RD_DIST_A,
    DP_RD_DIST_B,
    DP_ADD_VERTEX,
    DP_RD_DEG_A,
    DP_ADD_EDGE,
    DP_ASG_INIT,
    DP_ASG_RD,
    DP_ASG_NEXT,
    DP_DFS_START,
    DP_DFS_DONE,
    DP_POP,
    DP_NODE,
    DP_NB_RD,
    DP_NB_DFS,
    DP_BFS_START,
    DP_DEQ,
    DP_NB_BFS,
    DP_WALK_INIT,
    DP_WALK_STEP,
    DP_WALK_PAR,
    DP_WALK_END,
    DP_EMIT_RD,
    DP_EMIT_KEY
  } dp_op_t;

  typedef enum logic [1:0] {
    DS_NONE,
    DS_READ,
    DS_PATH
  } dsel_t;

  typedef enum logic [1:0] {
    CS_NONE,
    CS_ASG,
    CS_HOPS
  } csel_t;

  typedef struct packed {
    dp_op_t  op;
    logic    emit;
    status_t status;
    dsel_t   dsel;
    csel_t   csel;
    logic    path;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic a_found;
    logic b_found;
    logic same_ab;
    logic full;
    logic deg_full;
    logic dist_zero;
    logic ends_unassigned;
    logic ends_differ;
    logic sp_zero;
    logic q_empty;
    logic j_end;
    logic found;
    logic walk_end;
    logic emit_done;
  } stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CMP,
    S_DISPATCH,
    S_VTX_DUP,
    S_EDGE_CHK,
    S_QUERY_OUT,
    S_PATH_DB,
    S_PATH_CHK,
    S_ASG_RD,
    S_ASG_CHK,
    S_DFS_POP,
    S_DFS_NODE,
    S_DFS_NB_RD,
    S_DFS_NB,
    S_BFS_LOOP,
    S_BFS_NODE,
    S_BFS_NB_RD,
    S_BFS_NB,
    S_WALK,
    S_WALK_PAR,
    S_EMIT_RD,
    S_EMIT_KEY,
    S_EMIT_OUT
  } state_t;

endpackage

### rtl/graph_component_label_and_bfs_path.sv
// ----------------------------------------------------------------------------
// graph_component_label_and_bfs_path
// Directed-graph engine: vertex table, adjacency lists, district labeling
// by depth-first search, shortest path by breadth-first search.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive opcode/first_key/second_key and pulse start; the
//   transaction is taken on a clock edge with start high and busy low.
//   Unused opcodes are taken and dropped with no result.
//   Result channel: valid is high for one cycle per result; status,
//   vertex_key, district, count and last are good in that cycle. There is
//   no backpressure: the receiver must take every result as it comes.
//   busy stays high from the cycle after a command is taken until the cycle
//   that issues its last result; that result shows up in the cycle after.
// Sequencing:
//   Every keyed command first scans the key memory, one vertex at a time.
//   Add vertex / add edge / read district then give a single result.
//   Assign labels each unlabeled vertex's district by depth-first search
//   over its edges; one result at the end.
//   Path runs a breadth-first search, walks the parent links back, and
//   gives one result per path vertex, the last one flagged by last.
//   The memories have one write and one registered read port each.
// Reset: synchronous rst empties the vertex table and clears all marks.
// ----------------------------------------------------------------------------
module graph_component_label_and_bfs_path import gcl_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEGREE   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OPC_W-1:0]    opcode,
  input  logic [KEY_W-1:0]    first_key,
  input  logic [KEY_W-1:0]    second_key,
  output logic                valid,
  output logic [STATUS_W-1:0] status,
  output logic [KEY_W-1:0]    vertex_key,
  output logic [DIST_W-1:0]   district,
  output logic [COUNT_W-1:0]  count,
  output logic                last
);

  // command from controller to datapath, flags back
  cmd_t  cmd;
  stat_t stat;

  gcl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .busy   (busy),
    .cmd    (cmd),
    .stat   (stat)
  );

  gcl_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .first_key  (first_key),
    .second_key (second_key),
    .valid      (valid),
    .status     (status),
    .vertex_key (vertex_key),
    .district   (district),
    .count      (count),
    .last       (last)
  );

endmodule

### rtl/gcl_dp.sv
// ----------------------------------------------------------------------------
// gcl_dp
// Datapath: vertex/adjacency memories, work list, visit marks, result regs.
// ----------------------------------------------------------------------------
module gcl_dp import gcl_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEGREE   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [KEY_W-1:0]    first_key,
  input  logic [KEY_W-1:0]    second_key,
  output logic                valid,
  output logic [STATUS_W-1:0] status,
  output logic [KEY_W-1:0]    vertex_key,
  output logic [DIST_W-1:0]   district,
  output logic [COUNT_W-1:0]  count,
  output logic                last
);

  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int CW     = $clog2(MAX_VERTICES + 1);
  localparam int IDW    = $clog2(MAX_VERTICES + 2);
  localparam int JW     = $clog2(MAX_DEGREE + 1);
  localparam int NDEPTH = MAX_VERTICES * MAX_DEGREE;
  localparam int NAW    = $clog2(NDEPTH);

  logic [KEY_W-1:0] key_mem  [MAX_VERTICES];
  logic [VW-1:0]    nb_mem   [NDEPTH];
  logic [JW-1:0]    deg_mem  [MAX_VERTICES];
  logic [CW-1:0]    dist_mem [MAX_VERTICES];
  logic [VW-1:0]    par_mem  [MAX_VERTICES];
  logic [VW-1:0]    wl_mem   [MAX_VERTICES];

  logic [KEY_W-1:0] key_rd;
  logic [VW-1:0]    nb_rd;
  logic [JW-1:0]    deg_rd;
  logic [CW-1:0]    dist_rd;
  logic [VW-1:0]    par_rd;
  logic [VW-1:0]    wl_rd;

  logic             key_we, key_re;
  logic [VW-1:0]    key_wa, key_ra;
  logic             nb_we, nb_re;
  logic [NAW-1:0]   nb_wa, nb_ra;
  logic [VW-1:0]    nb_wd;
  logic             deg_we, deg_re;
  logic [VW-1:0]    deg_wa, deg_ra;
  logic [JW-1:0]    deg_wd;
  logic             dist_we, dist_re;
  logic [VW-1:0]    dist_wa, dist_ra;
  logic [CW-1:0]    dist_wd;
  logic             par_we, par_re;
  logic [VW-1:0]    par_wa, par_ra;
  logic [VW-1:0]    par_wd;
  logic             wl_we, wl_re;
  logic [VW-1:0]    wl_wa, wl_ra;
  logic [VW-1:0]    wl_wd;

  logic [KEY_W-1:0] k1, k2;
  logic [CW-1:0]    vcount;
  logic [CW-1:0]    idx;
  logic [VW-1:0]    a, b;
  logic             a_found, b_found;
  logic [IDW-1:0]   next_id;
  logic [VW-1:0]    node;
  logic [JW-1:0]    j;
  logic [CW-1:0]    wl_cnt;
  logic [CW-1:0]    head;
  logic [CW-1:0]    da, d;
  logic             found;
  logic [VW-1:0]    w;
  logic [CW-1:0]    n;
  logic [CW-1:0]    hops;
  logic [MAX_VERTICES-1:0] visited;

  logic [CW-1:0]    wl_cnt_m1, idx_m1;
  logic [IDW-1:0]   made;
  logic             nb_ok;

  assign wl_cnt_m1 = wl_cnt - CW'(1);
  assign idx_m1    = idx - CW'(1);
  assign made      = next_id - IDW'(1);

  // neighbor can be taken: in range, not yet seen, list has room
  assign nb_ok = (CW'(nb_rd) < CW'(MAX_VERTICES)) && !visited[nb_rd] &&
                 (wl_cnt < CW'(MAX_VERTICES));

  always_comb begin
    stat.scan_end        = (idx == vcount);
    stat.a_found         = a_found;
    stat.b_found         = b_found;
    stat.same_ab         = (a == b);
    stat.full            = (vcount == CW'(MAX_VERTICES));
    stat.deg_full        = (deg_rd >= JW'(MAX_DEGREE));
    stat.dist_zero       = (dist_rd == '0);
    stat.ends_unassigned = (da == '0) || (dist_rd == '0);
    stat.ends_differ     = (da != dist_rd);
    stat.sp_zero         = (wl_cnt == '0);
    stat.q_empty         = (head == wl_cnt);
    stat.j_end           = (j == deg_rd);
    stat.found           = found;
    stat.walk_end        = (w == a) || (n >= CW'(MAX_VERTICES - 1));
    stat.emit_done       = (idx == '0);
  end

  always_comb begin
    key_we = 1'b0; key_re = 1'b0; key_wa = '0; key_ra = '0;
    nb_we = 1'b0; nb_re = 1'b0; nb_wa = '0; nb_ra = '0; nb_wd = '0;
    deg_we = 1'b0; deg_re = 1'b0; deg_wa = '0; deg_ra = '0; deg_wd = '0;
    dist_we = 1'b0; dist_re = 1'b0; dist_wa = '0; dist_ra = '0; dist_wd = '0;
    par_we = 1'b0; par_re = 1'b0; par_wa = '0; par_ra = '0; par_wd = '0;
    wl_we = 1'b0; wl_re = 1'b0; wl_wa = '0; wl_ra = '0; wl_wd = '0;
    unique case (cmd.op)
      DP_FIND_RD: begin
        key_re = 1'b1; key_ra = idx[VW-1:0];
      end
      DP_RD_DIST_A: begin
        dist_re = 1'b1; dist_ra = a;
      end
      DP_RD_DIST_B: begin
        dist_re = 1'b1; dist_ra = b;
      end
      DP_ASG_RD: begin
        dist_re = 1'b1; dist_ra = idx[VW-1:0];
      end
      DP_ADD_VERTEX: begin
        key_we  = 1'b1; key_wa  = vcount[VW-1:0];
        deg_we  = 1'b1; deg_wa  = vcount[VW-1:0];
        dist_we = 1'b1; dist_wa = vcount[VW-1:0];
      end
      DP_RD_DEG_A: begin
        deg_re = 1'b1; deg_ra = a;
      end
      DP_ADD_EDGE: begin
        nb_we  = 1'b1;
        nb_wa  = NAW'(a) * NAW'(MAX_DEGREE) + NAW'(deg_rd);
        nb_wd  = b;
        deg_we = 1'b1; deg_wa = a; deg_wd = deg_rd + JW'(1);
      end
      DP_DFS_START: begin
        dist_we = 1'b1; dist_wa = idx[VW-1:0]; dist_wd = CW'(next_id);
        wl_we   = 1'b1; wl_wa = '0; wl_wd = idx[VW-1:0];
      end
      DP_POP: begin
        wl_re = 1'b1; wl_ra = wl_cnt_m1[VW-1:0];
      end
      DP_NODE: begin
        deg_re = 1'b1; deg_ra = wl_rd;
      end
      DP_NB_RD: begin
        nb_re = 1'b1; nb_ra = NAW'(node) * NAW'(MAX_DEGREE) + NAW'(j);
      end
      DP_NB_DFS: begin
        if (nb_ok) begin
          dist_we = 1'b1; dist_wa = nb_rd; dist_wd = CW'(next_id);
          wl_we   = 1'b1; wl_wa = wl_cnt[VW-1:0]; wl_wd = nb_rd;
        end
      end
      DP_BFS_START: begin
        wl_we = 1'b1; wl_wa = '0; wl_wd = a;
      end
      DP_DEQ: begin
        wl_re = 1'b1; wl_ra = head[VW-1:0];
      end
      DP_NB_BFS: begin
        if (nb_ok) begin
          par_we = 1'b1; par_wa = nb_rd; par_wd = node;
          wl_we  = 1'b1; wl_wa = wl_cnt[VW-1:0]; wl_wd = nb_rd;
        end
      end
      DP_WALK_STEP: begin
        wl_we  = 1'b1; wl_wa = n[VW-1:0]; wl_wd = w;
        par_re = 1'b1; par_ra = w;
      end
      DP_WALK_END: begin
        wl_we = 1'b1; wl_wa = n[VW-1:0]; wl_wd = a;
      end
      DP_EMIT_RD: begin
        wl_re = 1'b1; wl_ra = idx_m1[VW-1:0];
      end
      DP_EMIT_KEY: begin
        key_re = 1'b1; key_ra = wl_rd;
      end
      default: begin
      end
    endcase
  end

  // memories: one write and one registered read port each
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= k1;
    if (key_re) key_rd <= key_mem[key_ra];
  end

  always_ff @(posedge clk) begin
    if (nb_we) nb_mem[nb_wa] <= nb_wd;
    if (nb_re) nb_rd <= nb_mem[nb_ra];
  end

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    if (deg_re) deg_rd <= deg_mem[deg_ra];
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    if (dist_re) dist_rd <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    if (par_re) par_rd <= par_mem[par_ra];
  end

  always_ff @(posedge clk) begin
    if (wl_we) wl_mem[wl_wa] <= wl_wd;
    if (wl_re) wl_rd <= wl_mem[wl_ra];
  end

  // control state: vertex count, visit marks, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      vcount  <= '0;
      visited <= '0;
    end else begin
      valid <= cmd.emit;
      case (cmd.op)
        DP_ADD_VERTEX: vcount <= vcount + CW'(1);
        // clear all marks, then mark the root
        DP_DFS_START: visited <= MAX_VERTICES'(1) << idx[VW-1:0];
        DP_BFS_START: visited <= MAX_VERTICES'(1) << a;
        DP_NB_DFS, DP_NB_BFS: begin
          if (nb_ok) visited[nb_rd] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LATCH: begin
        k1      <= first_key;
        k2      <= second_key;
        idx     <= '0;
        a_found <= 1'b0;
        b_found <= 1'b0;
      end
      DP_FIND_CMP: begin
        if (!a_found && key_rd == k1) begin
          a       <= idx[VW-1:0];
          a_found <= 1'b1;
        end
        if (!b_found && key_rd == k2) begin
          b       <= idx[VW-1:0];
          b_found <= 1'b1;
        end
        idx <= idx + CW'(1);
      end
      DP_RD_DIST_B: da <= dist_rd;
      DP_ASG_INIT: begin
        k1      <= first_key;
        idx     <= '0;
        next_id <= IDW'(1);
      end
      DP_ASG_NEXT: idx <= idx + CW'(1);
      DP_DFS_START: wl_cnt <= CW'(1);
      DP_DFS_DONE: begin
        next_id <= next_id + IDW'(1);
        idx     <= idx + CW'(1);
      end
      DP_POP: wl_cnt <= wl_cnt_m1;
      DP_NODE: begin
        node <= wl_rd;
        j    <= '0;
      end
      DP_NB_DFS: begin
        j <= j + JW'(1);
        if (nb_ok) wl_cnt <= wl_cnt + CW'(1);
      end
      DP_BFS_START: begin
        d      <= da;
        wl_cnt <= CW'(1);
        head   <= '0;
        found  <= (a == b);
      end
      DP_DEQ: head <= head + CW'(1);
      DP_NB_BFS: begin
        j <= j + JW'(1);
        if (nb_ok) begin
          wl_cnt <= wl_cnt + CW'(1);
          if (nb_rd == b) found <= 1'b1;
        end
      end
      DP_WALK_INIT: begin
        w <= b;
        n <= '0;
      end
      DP_WALK_STEP: n <= n + CW'(1);
      DP_WALK_PAR: w <= par_rd;
      DP_WALK_END: begin
        idx  <= n + CW'(1);
        hops <= n;
      end
      DP_EMIT_RD: idx <= idx_m1;
      default: begin
      end
    endcase
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status     <= cmd.status;
      vertex_key <= cmd.path ? key_rd : k1;
      last       <= cmd.last;
      case (cmd.dsel)
        DS_READ: district <= DIST_W'(dist_rd);
        DS_PATH: district <= DIST_W'(d);
        default: district <= '0;
      endcase
      case (cmd.csel)
        CS_ASG:  count <= COUNT_W'(made);
        CS_HOPS: count <= COUNT_W'(hops);
        default: count <= '0;
      endcase
    end
  end

endmodule

### rtl/gcl_ctrl.sv
// ----------------------------------------------------------------------------
// gcl_ctrl
// Controller: sequences lookup, labeling search, breadth-first path search.
// ----------------------------------------------------------------------------
module gcl_ctrl import gcl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [OPC_W-1:0] opcode,
  output logic             busy,
  output cmd_t             cmd,
  input  stat_t            stat
);

  state_t state, state_next;
  opc_t   opc, opc_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      opc   <= OPC_ADD_VERTEX;
    end else begin
      state <= state_next;
      opc   <= opc_next;
    end
  end

  always_comb begin
    state_next = state;
    opc_next   = opc;
    cmd        = '{op: DP_NOP, emit: 1'b0, status: ST_OK, dsel: DS_NONE,
                   csel: CS_NONE, path: 1'b0, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (opcode)
            OPC_ADD_VERTEX, OPC_ADD_EDGE, OPC_QUERY, OPC_PATH: begin
              cmd.op     = DP_LATCH;
              opc_next   = opc_t'(opcode);
              state_next = S_FIND_RD;
            end
            OPC_ASSIGN: begin
              cmd.op     = DP_ASG_INIT;
              state_next = S_ASG_RD;
            end
            default: begin
            end
          endcase
        end
      end
      S_FIND_RD: begin
        if (stat.scan_end) begin
          state_next = S_DISPATCH;
        end else begin
          cmd.op     = DP_FIND_RD;
          state_next = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        cmd.op     = DP_FIND_CMP;
        state_next = S_FIND_RD;
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        unique case (opc)
          OPC_ADD_VERTEX: begin
            if (stat.a_found) begin
              cmd.op     = DP_RD_DIST_A;
              state_next = S_VTX_DUP;
            end else if (stat.full) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_FULL;
            end else begin
              cmd.op   = DP_ADD_VERTEX;
              cmd.emit = 1'b1;
            end
          end
          OPC_ADD_EDGE: begin
            if (!stat.a_found || !stat.b_found) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_UNKNOWN;
            end else if (stat.same_ab) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_SELF_LOOP;
            end else begin
              cmd.op     = DP_RD_DEG_A;
              state_next = S_EDGE_CHK;
            end
          end
          OPC_QUERY: begin
            if (!stat.a_found) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_UNKNOWN;
            end else begin
              cmd.op     = DP_RD_DIST_A;
              state_next = S_QUERY_OUT;
            end
          end
          default: begin
            if (!stat.a_found || !stat.b_found) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_UNKNOWN;
            end else begin
              cmd.op     = DP_RD_DIST_A;
              state_next = S_PATH_DB;
            end
          end
        endcase
      end
      S_VTX_DUP: begin
        cmd.emit   = 1'b1;
        cmd.status = ST_DUP;
        cmd.dsel   = DS_READ;
        state_next = S_IDLE;
      end
      S_EDGE_CHK: begin
        cmd.emit = 1'b1;
        if (stat.deg_full) cmd.status = ST_ADJ_FULL;
        else cmd.op = DP_ADD_EDGE;
        state_next = S_IDLE;
      end
      S_QUERY_OUT: begin
        cmd.emit   = 1'b1;
        cmd.dsel   = DS_READ;
        state_next = S_IDLE;
      end
      S_PATH_DB: begin
        cmd.op     = DP_RD_DIST_B;
        state_next = S_PATH_CHK;
      end
      S_PATH_CHK: begin
        if (stat.ends_unassigned) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_UNASSIGNED;
          state_next = S_IDLE;
        end else if (stat.ends_differ) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_OTHER_DIST;
          state_next = S_IDLE;
        end else begin
          cmd.op     = DP_BFS_START;
          state_next = S_BFS_LOOP;
        end
      end
      S_ASG_RD: begin
        if (stat.scan_end) begin
          cmd.emit   = 1'b1;
          cmd.csel   = CS_ASG;
          state_next = S_IDLE;
        end else begin
          cmd.op     = DP_ASG_RD;
          state_next = S_ASG_CHK;
        end
      end
      S_ASG_CHK: begin
        if (stat.dist_zero) begin
          cmd.op     = DP_DFS_START;
          state_next = S_DFS_POP;
        end else begin
          cmd.op     = DP_ASG_NEXT;
          state_next = S_ASG_RD;
        end
      end
      S_DFS_POP: begin
        if (stat.sp_zero) begin
          cmd.op     = DP_DFS_DONE;
          state_next = S_ASG_RD;
        end else begin
          cmd.op     = DP_POP;
          state_next = S_DFS_NODE;
        end
      end
      S_DFS_NODE: begin
        cmd.op     = DP_NODE;
        state_next = S_DFS_NB_RD;
      end
      S_DFS_NB_RD: begin
        if (stat.j_end) begin
          state_next = S_DFS_POP;
        end else begin
          cmd.op     = DP_NB_RD;
          state_next = S_DFS_NB;
        end
      end
      S_DFS_NB: begin
        cmd.op     = DP_NB_DFS;
        state_next = S_DFS_NB_RD;
      end
      S_BFS_LOOP: begin
        if (stat.found) begin
          cmd.op     = DP_WALK_INIT;
          state_next = S_WALK;
        end else if (stat.q_empty) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_UNREACHABLE;
          cmd.dsel   = DS_PATH;
          state_next = S_IDLE;
        end else begin
          cmd.op     = DP_DEQ;
          state_next = S_BFS_NODE;
        end
      end
      S_BFS_NODE: begin
        cmd.op     = DP_NODE;
        state_next = S_BFS_NB_RD;
      end
      S_BFS_NB_RD: begin
        if (stat.found || stat.j_end) begin
          state_next = S_BFS_LOOP;
        end else begin
          cmd.op     = DP_NB_RD;
          state_next = S_BFS_NB;
        end
      end
      S_BFS_NB: begin
        cmd.op     = DP_NB_BFS;
        state_next = S_BFS_NB_RD;
      end
      S_WALK: begin
        if (stat.walk_end) begin
          cmd.op     = DP_WALK_END;
          state_next = S_EMIT_RD;
        end else begin
          cmd.op     = DP_WALK_STEP;
          state_next = S_WALK_PAR;
        end
      end
      S_WALK_PAR: begin
        cmd.op     = DP_WALK_PAR;
        state_next = S_WALK;
      end
      S_EMIT_RD: begin
        cmd.op     = DP_EMIT_RD;
        state_next = S_EMIT_KEY;
      end
      S_EMIT_KEY: begin
        cmd.op     = DP_EMIT_KEY;
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        cmd.emit   = 1'b1;
        cmd.dsel   = DS_PATH;
        cmd.csel   = CS_HOPS;
        cmd.path   = 1'b1;
        cmd.last   = stat.emit_done;
        state_next = stat.emit_done ? S_IDLE : S_EMIT_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
